// ===== hw/rtl/tssp_pkg.sv =====
// shared types, constants and helper functions of the three-segment speed profile unit
`default_nettype none

package tssp_pkg;

  localparam int unsigned SEGMENT_COUNT = 3;
  localparam int unsigned LEN_W         = 40;
  localparam int unsigned LEFT_W        = LEN_W + 1;
  localparam int unsigned SPEED_W       = 16;
  localparam int unsigned FREQ_W        = 24;
  localparam int unsigned PROD_W        = 2 * SPEED_W;
  localparam int unsigned TICK_MS       = 5;
  localparam int unsigned IDLE_SPEED    = 15;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IN_DATA_W     = 3 * LEN_W;
  localparam int unsigned OUT_DATA_W    = 32;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [LEFT_W-1:0]  left_t;
  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic [FREQ_W-1:0]  freq_t;

  typedef left_t  [SEGMENT_COUNT-1:0] left_arr_t;
  typedef speed_t [SEGMENT_COUNT-1:0] speed_arr_t;

  // idle speed in u8.8, gives exactly 15 * gain after the shift
  localparam speed_t IDLE_SPEED_RAW = SPEED_W'(IDLE_SPEED << 8);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TIMED = 2'd1,
    OP_DIST  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_SPEED_FIRST  = 2'd0,
    REG_SPEED_SECOND = 2'd1,
    REG_SPEED_THIRD  = 2'd2,
    REG_FREQ_GAIN    = 2'd3
  } reg_e;

  typedef struct packed {
    speed_t speed_first;
    speed_t speed_second;
    speed_t speed_third;
    speed_t freq_gain;
  } cfg_t;

  // result of one tick over one mode's segments
  typedef struct packed {
    logic   done;
    speed_t speed;
  } mode_res_t;

  function automatic logic left_pos(left_t v);
    return !v[LEFT_W-1] && (|v);
  endfunction

  function automatic speed_t seg_speed(int unsigned idx, cfg_t cfg);
    case (idx)
      0:       return cfg.speed_first;
      1:       return cfg.speed_second;
      2:       return cfg.speed_third;
      default: return '0;
    endcase
  endfunction

  function automatic left_t load_len(int unsigned idx, len_t l0, len_t l1, len_t l2);
    case (idx)
      0:       return {1'b0, l0};
      1:       return {1'b0, l1};
      2:       return {1'b0, l2};
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tssp_cfg.sv =====
// apb register bank for segment speeds and frequency gain
`default_nettype none

module tssp_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tssp_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tssp_pkg::DATA_W-1:0]  pwdata,
  output logic      [tssp_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output tssp_pkg::cfg_t                    cfg_o
);
  import tssp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_SPEED_FIRST:  cfg_d.speed_first  = pwdata[SPEED_W-1:0];
        REG_SPEED_SECOND: cfg_d.speed_second = pwdata[SPEED_W-1:0];
        REG_SPEED_THIRD:  cfg_d.speed_third  = pwdata[SPEED_W-1:0];
        REG_FREQ_GAIN:    cfg_d.freq_gain    = pwdata[SPEED_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SPEED_FIRST:  prdata = DATA_W'(cfg_q.speed_first);
      REG_SPEED_SECOND: prdata = DATA_W'(cfg_q.speed_second);
      REG_SPEED_THIRD:  prdata = DATA_W'(cfg_q.speed_third);
      REG_FREQ_GAIN:    prdata = DATA_W'(cfg_q.freq_gain);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_first  <= '0;
      cfg_q.speed_second <= '0;
      cfg_q.speed_third  <= '0;
      cfg_q.freq_gain    <= SPEED_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tssp_mode.sv =====
// one tick over the segments of one mode: ordered compare and subtract chain
`default_nettype none

module tssp_mode (
  input  wire tssp_pkg::left_arr_t  left_i,
  input  wire tssp_pkg::speed_arr_t speed_i,
  input  wire logic                 by_dist_i,
  output tssp_pkg::left_arr_t       left_o,
  output tssp_pkg::mode_res_t       res_o
);
  import tssp_pkg::*;

  logic   earlier;
  speed_t sel_speed;
  left_t  step;

  always_comb begin
    earlier   = 1'b1;
    sel_speed = '0;
    step      = '0;
    for (int i = 0; i < SEGMENT_COUNT; i++) begin
      step = by_dist_i ? LEFT_W'(speed_i[i]) : LEFT_W'(TICK_MS);
      if (left_pos(left_i[i]) && earlier) begin
        left_o[i] = left_i[i] - step;
        sel_speed = speed_i[i];
      end else begin
        left_o[i] = left_i[i];
      end
      // a segment still positive holds back the later ones
      if (left_pos(left_o[i])) begin
        earlier = 1'b0;
      end
    end
    res_o.done  = earlier;
    res_o.speed = earlier ? IDLE_SPEED_RAW : sel_speed;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/three_segment_speed_profile_unit.sv =====
// top level of the three-segment speed profile unit: pipeline, profile state and frequency
// flow: a transaction accepted into the input register is processed when the result register
//   can advance, and its result then stays valid on the master side until it is taken
// throughput: one transaction per cycle unless the master side stalls, bounded by the state
//   update loop (segment compare and subtract chain, speed select and one 16x16 multiply)
// reset: asynchronous, clears segment speeds, remaining lengths, run flags and held frequency, sets gain to 1
`default_nettype none

module three_segment_speed_profile_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tssp_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [tssp_pkg::DATA_W-1:0]       pwdata,
  output logic      [tssp_pkg::DATA_W-1:0]       prdata,
  output logic                                   pready,
  // input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata fields from bit 0: len_first[39:0], len_second[79:40], len_third[119:80]
  input  wire logic [tssp_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser fields from bit 0: op[1:0]
  input  wire logic [1:0]                        s_axis_tuser_i,
  // result stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata fields from bit 0: drive_freq[23:0], timed_busy[24], distance_busy[25],
  //   stop_pulse[26], zero padding[31:27]
  output logic      [tssp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import tssp_pkg::*;

  cfg_t cfg;

  tssp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the processing edge, result register waits
  // for the master side; a new transaction can enter while a result is held if the
  // input register is empty
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_fire;
  logic proc_fire;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign proc_fire       = in_valid_q && advance;

  logic [1:0] in_op_q;
  len_t       in_len0_q, in_len1_q, in_len2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (proc_fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_op_q   <= s_axis_tuser_i;
      in_len0_q <= s_axis_tdata_i[LEN_W-1:0];
      in_len1_q <= s_axis_tdata_i[2*LEN_W-1:LEN_W];
      in_len2_q <= s_axis_tdata_i[3*LEN_W-1:2*LEN_W];
    end
  end

  // ---------------------------------------------------------------------------
  // profile state
  // ---------------------------------------------------------------------------
  left_arr_t time_left_q, time_left_d;
  left_arr_t dist_left_q, dist_left_d;
  logic      timed_run_q, timed_run_d;
  logic      dist_run_q, dist_run_d;
  freq_t     freq_hold_q, freq_hold_d;
  logic      stop_d;

  speed_arr_t seg_speeds;
  left_arr_t  load_lens;

  // per-segment speeds and start lengths; segments past the third get zero
  always_comb begin
    for (int i = 0; i < SEGMENT_COUNT; i++) begin
      seg_speeds[i] = seg_speed(i, cfg);
      load_lens[i]  = load_len(i, in_len0_q, in_len1_q, in_len2_q);
    end
  end

  left_arr_t time_left_tick, dist_left_tick;
  mode_res_t timed_res, dist_res;

  tssp_mode u_mode_timed (
    .left_i    (time_left_q),
    .speed_i   (seg_speeds),
    .by_dist_i (1'b0),
    .left_o    (time_left_tick),
    .res_o     (timed_res)
  );

  tssp_mode u_mode_dist (
    .left_i    (dist_left_q),
    .speed_i   (seg_speeds),
    .by_dist_i (1'b1),
    .left_o    (dist_left_tick),
    .res_o     (dist_res)
  );

  // distance mode is handled second, so its speed wins when both run
  speed_t              freq_speed;
  logic [PROD_W-1:0]   freq_prod;

  assign freq_speed = dist_run_q ? dist_res.speed : timed_res.speed;
  assign freq_prod  = PROD_W'(freq_speed) * PROD_W'(cfg.freq_gain);

  always_comb begin
    time_left_d = time_left_q;
    dist_left_d = dist_left_q;
    timed_run_d = timed_run_q;
    dist_run_d  = dist_run_q;
    freq_hold_d = freq_hold_q;
    stop_d      = 1'b0;
    if (proc_fire) begin
      case (in_op_q)
        OP_TIMED: begin
          // a start while running restarts that mode, frequency untouched
          time_left_d = load_lens;
          timed_run_d = 1'b1;
        end
        OP_DIST: begin
          dist_left_d = load_lens;
          dist_run_d  = 1'b1;
        end
        OP_TICK: begin
          if (timed_run_q) begin
            time_left_d = time_left_tick;
            if (timed_res.done) begin
              timed_run_d = 1'b0;
              stop_d      = 1'b1;
            end
          end
          if (dist_run_q) begin
            dist_left_d = dist_left_tick;
            if (dist_res.done) begin
              dist_run_d = 1'b0;
              stop_d     = 1'b1;
            end
          end
          if (timed_run_q || dist_run_q) begin
            freq_hold_d = freq_prod[PROD_W-1:8];
          end
        end
        default: begin
          // unused op code: status only
          stop_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_left_q <= '0;
      dist_left_q <= '0;
      timed_run_q <= 1'b0;
      dist_run_q  <= 1'b0;
      freq_hold_q <= '0;
    end else begin
      time_left_q <= time_left_d;
      dist_left_q <= dist_left_d;
      timed_run_q <= timed_run_d;
      dist_run_q  <= dist_run_d;
      freq_hold_q <= freq_hold_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  freq_t out_freq_q;
  logic  out_timed_q, out_dist_q, out_stop_q;

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_freq_q  <= freq_hold_d;
      out_timed_q <= timed_run_d;
      out_dist_q  <= dist_run_d;
      out_stop_q  <= stop_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - FREQ_W - 3)'(0),
                            out_stop_q, out_dist_q, out_timed_q, out_freq_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // a finishing tick clears at least one run flag, so both cannot be busy
  a_stop_not_both_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stop_q |-> !(out_timed_q && out_dist_q))
    else $error("stop transaction with both modes still busy");

  // the timed run flag only rises from a processed timed start
  a_timed_rise_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(timed_run_q) |-> $past(proc_fire && (in_op_q == OP_TIMED)))
    else $error("timed run started without a timed start transaction");

  // the distance run flag only rises from a processed distance start
  a_dist_rise_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(dist_run_q) |-> $past(proc_fire && (in_op_q == OP_DIST)))
    else $error("distance run started without a distance start transaction");

  // the held frequency only moves on a processed tick
  a_freq_moves_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(freq_hold_q) |-> $past(proc_fire && (in_op_q == OP_TICK)))
    else $error("drive frequency changed outside a tick transaction");

endmodule

`default_nettype wire
